### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RKTH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

`define RKTH_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: check failed");

`else

`define RKTH_ASSERT(lbl, clk, rst, prop)

`define RKTH_ASSERT_NEXT(lbl, clk, rst, cond, prop)

`endif

`endif

### rtl/rkth_pkg.sv
`default_nettype none

package rkth_pkg;

   localparam int SAMPLE_W = 32;
   localparam int RANK_W   = 7;
   localparam logic [RANK_W-1:0] RANK_K_RESET = 7'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOPCHK,
      ST_CHECK,
      ST_PLACE,
      ST_FETCH,
      ST_RESPOND
   } rkth_state_type;

   typedef struct packed {
      logic load;
      logic full;
   } rkth_rsp_ctl_type;

endpackage

`default_nettype wire

### rtl/rkth_ram.sv
`default_nettype none

module rkth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/rkth_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module rkth_ctrl import rkth_pkg::*; #(
   parameter int K_MAX = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [RANK_W-1:0]                       rank_k,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic signed [SAMPLE_W-1:0]              req_sample,
   input  wire logic                                    rsp_busy,
   input  wire logic [SAMPLE_W-1:0]                     rd_data,
   output logic                                         ram_we,
   output logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] ram_waddr,
   output logic [SAMPLE_W-1:0]                          ram_wdata,
   output logic                                         ram_re,
   output logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] ram_raddr,
   output rkth_rsp_ctl_type                             rsp_ctl
);

   localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int CW = $clog2(K_MAX + 1);
   localparam int KW = (CW > RANK_W) ? CW : RANK_W;

   rkth_state_type              state_ff, state_in;
   logic [CW-1:0]               held_ff, held_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic signed [SAMPLE_W-1:0]  sample_ff, sample_in;

   logic [KW-1:0] rank_w, k_w, held_w;
   logic          fill_mode;
   logic          rd_gt;

   always_comb begin
      rank_w = KW'(rank_k);
      priority if (rank_w == '0) begin
         k_w = KW'(1);
      end else if (rank_w > KW'(K_MAX)) begin
         k_w = KW'(K_MAX);
      end else begin
         k_w = rank_w;
      end
      held_w    = KW'(held_ff);
      fill_mode = held_w < k_w;
   end

   // shared comparator: stored word above the incoming sample
   assign rd_gt = $signed(rd_data) > sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
      pos_ff    <= pos_in;
      sample_ff <= sample_in;
   end

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = sample_ff;
      ram_re       = 1'b0;
      ram_raddr    = pos_ff - AW'(1);
      rsp_ctl.load = 1'b0;
      rsp_ctl.full = held_w >= k_w;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sample_in = req_sample;
               if (fill_mode) begin
                  held_in = held_ff + CW'(1);
                  pos_in  = AW'(held_ff);
                  if (held_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = AW'(held_ff - CW'(1));
                     state_in  = ST_CHECK;
                  end
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(held_ff - CW'(1));
                  state_in  = ST_TOPCHK;
               end
            end
         end
         ST_TOPCHK: begin
            if (rd_gt) begin
               pos_in = AW'(held_ff - CW'(1));
               if (held_ff == CW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(held_ff - CW'(2));
                  state_in  = ST_CHECK;
               end
            end else begin
               // hold the read word, it is the result
               state_in = ST_RESPOND;
            end
         end
         ST_CHECK: begin
            ram_we = 1'b1;
            if (rd_gt) begin
               ram_wdata = rd_data;
               pos_in    = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = pos_ff - AW'(2);
               end
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_PLACE: begin
            ram_we   = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(held_ff - CW'(1));
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_busy) begin
               rsp_ctl.load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `RKTH_ASSERT(a_held_le_kmax, clock, reset, held_ff <= CW'(K_MAX))
   `RKTH_ASSERT(a_wr_below_held, clock, reset, !ram_we || (CW'(ram_waddr) < held_ff))
   `RKTH_ASSERT(a_no_wr_idle, clock, reset, (state_ff != ST_IDLE) || !ram_we)
   `RKTH_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

endmodule

`default_nettype wire

### rtl/running_kth_smallest_core.sv
// Running k-th smallest selector.
// Input: req_valid/req_ready with req_sample, a signed 32-bit word.
// Output: rsp_valid/rsp_ready with rsp_kth_value, the largest of the k
// smallest samples seen so far, and rsp_window_full, set once k values
// are held. Every input word gives exactly one output word.
// Config: csr_wr_en/csr_wr_data write rank_k at once; 0 acts as 1 and values
// above K_MAX act as K_MAX. Write it only while the block is idle.
// The kept values sit sorted in one RAM; a single comparator walks down it,
// moving one entry per cycle until the new sample finds its slot.
// Steps after acceptance: a sample that is not kept goes from the top check
// to respond; one that fills the window walks down, is placed, then the top is
// fetched; one replacing the largest value does so after the top check.
// One word is in flight at a time; req_ready is low until the result is
// loaded into the output register.
// A finished result waits in the output register while rsp_ready is low;
// the next word is accepted meanwhile and its result waits for the slot.
// Reset (synchronous) empties the window and sets rank_k to 3.
`default_nettype none

`include "assert_macros.svh"

module running_kth_smallest_core import rkth_pkg::*; #(
   parameter int K_MAX = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [RANK_W-1:0]          csr_wr_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_kth_value,
   output logic                            rsp_window_full
);

   localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

   logic [RANK_W-1:0]   rank_k_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] kth_value_ff;
   logic                window_full_ff;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
   logic                rsp_busy;
   rkth_rsp_ctl_type    rsp_ctl;

   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   rkth_ctrl #(
      .K_MAX (K_MAX)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .rank_k     (rank_k_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_busy   (rsp_busy),
      .rd_data    (ram_rdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .rsp_ctl    (rsp_ctl)
   );

   rkth_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (K_MAX)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_k_ff    <= RANK_K_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rank_k_ff <= csr_wr_data;
         end
         if (rsp_ctl.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_ctl.load) begin
         kth_value_ff   <= ram_rdata;
         window_full_ff <= rsp_ctl.full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kth_value   = $signed(kth_value_ff);
   assign rsp_window_full = window_full_ff;

   `RKTH_ASSERT(a_load_into_free, clock, reset, !rsp_ctl.load || !rsp_busy)

endmodule

`default_nettype wire

### tb/sv/running_kth_smallest_checker.sv
module running_kth_smallest_checker import rkth_pkg::*; #(
   parameter int K_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [RANK_W-1:0]          csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_kth_value,
   input  logic                       rsp_window_full,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] kth_value;
      logic                       window_full;
   } kth_result_type;

   logic signed [SAMPLE_W-1:0] kept_sorted [K_MAX];
   int unsigned                kept_count;
   logic [RANK_W-1:0]          rank_k;
   kth_result_type             expected_kth_q [$];

   function automatic int unsigned clamped_rank();
      int unsigned k;
      k = rank_k;
      if (k == 0) k = 1;
      if (k > K_MAX) k = K_MAX;
      return k;
   endfunction

   // shift larger entries up until the new word finds its slot
   function automatic void place_sorted(input int unsigned top,
                                        input logic signed [SAMPLE_W-1:0] v);
      int unsigned pos;
      pos = top;
      while (pos > 0 && kept_sorted[pos-1] > v) begin
         kept_sorted[pos] = kept_sorted[pos-1];
         pos--;
      end
      kept_sorted[pos] = v;
   endfunction

   function automatic kth_result_type absorb_sample(input logic signed [SAMPLE_W-1:0] v);
      int unsigned k;
      kth_result_type r;
      k = clamped_rank();
      if (kept_count < k && kept_count < K_MAX) begin
         place_sorted(kept_count, v);
         kept_count++;
      end else if (kept_count > 0 && v < kept_sorted[kept_count-1]) begin
         place_sorted(kept_count - 1, v);
      end
      r.kth_value   = kept_sorted[kept_count-1];
      r.window_full = (kept_count >= k);
      return r;
   endfunction

   always @(posedge clock) begin
      kth_result_type want;
      if (reset) begin
         kept_count = 0;
         rank_k     = RANK_K_RESET;
         expected_kth_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_kth_q.size() == 0) begin
               $error("unexpected result word: kth_value %0d window_full %0b",
                      rsp_kth_value, rsp_window_full);
               fail_count++;
            end else begin
               want = expected_kth_q.pop_front();
               if (rsp_kth_value !== want.kth_value) begin
                  $error("kth_value: expected %0d, got %0d",
                         want.kth_value, rsp_kth_value);
                  fail_count++;
               end
               if (rsp_window_full !== want.window_full) begin
                  $error("window_full: expected %0b, got %0b",
                         want.window_full, rsp_window_full);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_kth_q.push_back(absorb_sample(req_sample));
         if (csr_wr_en) rank_k = csr_wr_data;
      end
      pending = expected_kth_q.size();
   end

endmodule

### tb/sv/running_kth_smallest_core_tb.sv
module running_kth_smallest_core_tb import rkth_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     K_MAX        = 64;
   localparam int     STALL_LIMIT  = 20000;
   localparam int     SETTLE       = K_MAX + 16;
   localparam int     PHASE_WORDS  = 69;
   localparam longint CURSOR_TOP   = 64'sd2147483647;
   localparam longint CURSOR_FLOOR = -64'sd2139095040;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       csr_wr_en       = 1'b0;
   logic [RANK_W-1:0]          csr_wr_data     = '0;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_kth_value;
   logic                       rsp_window_full;

   int     fail_count;
   int     pending;
   int     send_idle_pct = 29;
   int     recv_idle_pct = 46;
   int     idle_cycles   = 0;
   longint cursor        = CURSOR_TOP;

   int rank_plan [15] = '{2, 0, 5, 1, 12, 3, 127, 64, 1, 65, 0, 40, 2, 64, 7};

   initial begin
      forever #5 clock = ~clock;
   end

   running_kth_smallest_core #(.K_MAX(K_MAX)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kth_value  (rsp_kth_value),
      .rsp_window_full(rsp_window_full)
   );

   running_kth_smallest_checker #(.K_MAX(K_MAX)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kth_value  (rsp_kth_value),
      .rsp_window_full(rsp_window_full),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [SAMPLE_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_rank(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= RANK_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned sel;
      logic [SAMPLE_W-1:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         if ($urandom_range(0, 1) == 0) cursor = cursor - longint'($urandom_range(0, 3));
         else cursor = cursor - longint'($urandom_range(0, 1 << 22));
         if (cursor < CURSOR_FLOOR) cursor = CURSOR_TOP;
         v = cursor[SAMPLE_W-1:0];
      end else if (sel < 70) begin
         v = $urandom();
      end else if (sel < 85) begin
         v = SAMPLE_W'(cursor + longint'($urandom_range(0, 6)) - 64'sd3);
      end else begin
         case ($urandom_range(0, 5))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0001;
            3:       v = 32'h7FFF_FFFE;
            4:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end
      return v;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(32'h7FFF_FFFF);
      send_word(32'h8000_0000);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'h0000_0005);
      send_word(32'h8000_0000);
      wait_drained();
      write_rank(0);
      send_word(32'h0000_0001);
      send_word(32'hFFFF_FFFB);
      wait_drained();
      write_rank(127);
      send_word(32'h7FFF_FFFE);
      send_word(32'h8000_0001);
      send_word(32'h7FFF_FFFF);
      send_word(32'h0000_0007);
      wait_drained();
      write_rank(1);
      send_word(32'h0000_0003);
      send_word(32'h8000_0000);
      wait_drained();
      write_rank(64);
      send_word(32'h0000_0002);
      send_word(32'hFFFF_FFFE);

      for (int p = 0; p < 15; p++) begin
         wait_drained();
         if (p == 5) begin
            send_idle_pct = 46;
            recv_idle_pct = 29;
         end else if (p == 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_rank(rank_plan[p]);
         cursor = CURSOR_TOP;
         for (int i = 0; i < PHASE_WORDS; i++) send_word(pick_sample());
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
